FILE: rtl/core/afb_pkg.sv
// ----------------------------------------------------------------------------
// afb_pkg
// Shared types and constants of the alpha fade / blink sequencer.
// ----------------------------------------------------------------------------
package afb_pkg;

    localparam int DUR_W      = 16;
    localparam int LEVEL_W    = 17;
    localparam int RATE_W     = 18;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_TIME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HIGH = 2'd2;

    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_FADE_IN  = 2'd1,
        ACT_FADE_OUT = 2'd2,
        ACT_BLINK    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_IN    = 2'd1,
        MODE_OUT   = 2'd2,
        MODE_BLINK = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]       action;
        logic [DUR_W-1:0] duration;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] level_byte;
        logic [1:0]        mode;
    } t_out_item;

    typedef struct packed {
        t_action          act;
        logic             dur_zero;
        logic [DUR_W-1:0] duration;
    } t_cmd;

    typedef struct packed {
        logic [DUR_W-1:0]   tick_time;
        logic [LEVEL_W-1:0] blink_low;
        logic [LEVEL_W-1:0] blink_high;
    } t_cfg;

endpackage

FILE: rtl/core/afb_front.sv
// ----------------------------------------------------------------------------
// afb_front
// Input stage: takes items, decodes the action and registers the command.
// ----------------------------------------------------------------------------
module afb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  afb_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_stall,
    output afb_pkg::t_cmd     o_cmd
);

    logic          r_valid;
    afb_pkg::t_cmd r_cmd;
    afb_pkg::t_cmd n_cmd;

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_cmd.act      = afb_pkg::t_action'(i_item.action);
        n_cmd.dur_zero = (i_item.duration == '0);
        n_cmd.duration = i_item.duration;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= i_valid;
        end
        if (i_valid && !o_stall) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: rtl/core/afb_queue.sv
// ----------------------------------------------------------------------------
// afb_queue
// Two-entry command queue between the input stage and the execution unit.
// ----------------------------------------------------------------------------
module afb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  afb_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_stall,
    output afb_pkg::t_cmd o_cmd
);

    afb_pkg::t_cmd r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          push;
    logic          pop;

    assign o_stall = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/core/afb_div.sv
// ----------------------------------------------------------------------------
// afb_div
// Step rate divider: tick_time * 65536 / duration, one quotient bit a cycle,
// saturated to one full step.
// ----------------------------------------------------------------------------
module afb_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [afb_pkg::DUR_W-1:0]     i_num,
    input  logic [afb_pkg::DUR_W-1:0]     i_den,
    output logic                          o_done,
    output logic [afb_pkg::LEVEL_W-1:0]   o_quot
);

    localparam int CNT_W = $clog2(afb_pkg::DUR_W);

    logic                        r_busy;
    logic                        r_done;
    logic                        r_sat;
    logic [CNT_W-1:0]            r_cnt;
    logic [afb_pkg::DUR_W:0]     r_rem;
    logic [afb_pkg::DUR_W-1:0]   r_den;
    logic [afb_pkg::DUR_W-1:0]   r_quot;
    logic [afb_pkg::DUR_W:0]     rem_sh;
    logic                        q_bit;

    assign rem_sh = {r_rem[afb_pkg::DUR_W-1:0], 1'b0};
    assign q_bit  = (rem_sh >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quot = r_sat ? afb_pkg::FULL_LEVEL : {1'b0, r_quot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            // quotient reaches a full step exactly when tick_time >= duration
            r_busy <= (i_num < i_den);
            r_done <= (i_num >= i_den);
        end else if (r_busy && (r_cnt == '0)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
        if (i_start) begin
            r_sat  <= (i_num >= i_den);
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
            r_cnt  <= CNT_W'(afb_pkg::DUR_W - 1);
        end else if (r_busy) begin
            r_rem  <= q_bit ? (rem_sh - {1'b0, r_den}) : rem_sh;
            r_quot <= {r_quot[afb_pkg::DUR_W-2:0], q_bit};
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

endmodule

FILE: rtl/core/afb_back.sv
// ----------------------------------------------------------------------------
// afb_back
// Execution unit: holds level, rate and mode, runs commands and ticks and
// registers the result.
// ----------------------------------------------------------------------------
module afb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  afb_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  afb_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    input  logic               i_stall,
    output afb_pkg::t_out_item o_item
);

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    t_state                             r_state;
    afb_pkg::t_cmd                      r_cmd;
    logic [afb_pkg::LEVEL_W-1:0]        r_level;
    logic signed [afb_pkg::RATE_W-1:0]  r_rate;
    afb_pkg::t_mode                     r_mode;
    logic                               r_out_valid;
    afb_pkg::t_out_item                 r_out;

    logic [afb_pkg::LEVEL_W-1:0]        n_level;
    logic signed [afb_pkg::RATE_W-1:0]  n_rate;
    afb_pkg::t_mode                     n_mode;
    logic [afb_pkg::BYTE_W-1:0]         n_byte;

    afb_pkg::t_cmd                      cur_cmd;
    logic                               out_free;
    logic                               pop;
    logic                               div_start;
    logic                               div_done;
    logic [afb_pkg::LEVEL_W-1:0]        div_quot;
    logic                               apply;

    logic signed [afb_pkg::LEVEL_W+1:0] v_sum;
    logic signed [afb_pkg::LEVEL_W+1:0] v_lvl;
    logic signed [afb_pkg::LEVEL_W+1:0] v_full;
    logic signed [afb_pkg::LEVEL_W+1:0] v_hi;
    logic signed [afb_pkg::LEVEL_W+1:0] v_lo;
    logic signed [afb_pkg::RATE_W-1:0]  v_rate;
    logic [afb_pkg::LEVEL_W+7:0]        v_prod;

    assign out_free  = !r_out_valid || !i_stall;
    assign o_stall   = !((r_state == S_IDLE) && out_free);
    assign pop       = i_valid && !o_stall;
    assign div_start = pop && (i_cmd.act != afb_pkg::ACT_TICK);
    assign cur_cmd   = (r_state == S_DIV) ? r_cmd : i_cmd;
    assign apply     = (pop && (i_cmd.act == afb_pkg::ACT_TICK))
                    || ((r_state == S_DIV) && div_done && out_free);
    assign o_valid   = r_out_valid;
    assign o_item    = r_out;

    afb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (i_cfg.tick_time),
        .i_den   (i_cmd.duration),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        v_full = $signed({2'b00, afb_pkg::FULL_LEVEL});
        v_hi   = $signed({2'b00, i_cfg.blink_high});
        v_lo   = $signed({2'b00, i_cfg.blink_low});
        v_sum  = $signed({2'b00, r_level}) + $signed({r_rate[afb_pkg::RATE_W-1], r_rate});
        v_rate = $signed({1'b0, div_quot});
        v_lvl  = $signed({2'b00, r_level});
        n_rate = r_rate;
        n_mode = r_mode;
        unique case (cur_cmd.act)
            afb_pkg::ACT_FADE_IN: begin
                if (r_level == afb_pkg::FULL_LEVEL) begin
                    n_mode = afb_pkg::MODE_IDLE;
                end else if (cur_cmd.dur_zero) begin
                    n_mode = afb_pkg::MODE_IDLE;
                    v_lvl  = v_full;
                end else begin
                    n_mode = afb_pkg::MODE_IN;
                    v_lvl  = '0;
                    n_rate = v_rate;
                end
            end
            afb_pkg::ACT_FADE_OUT: begin
                if (cur_cmd.dur_zero) begin
                    n_mode = afb_pkg::MODE_IDLE;
                    v_lvl  = '0;
                end else begin
                    n_mode = afb_pkg::MODE_OUT;
                    v_lvl  = v_full;
                    n_rate = -v_rate;
                end
            end
            afb_pkg::ACT_BLINK: begin
                if ((r_mode == afb_pkg::MODE_IDLE) || (r_mode == afb_pkg::MODE_BLINK)) begin
                    n_mode = afb_pkg::MODE_BLINK;
                    n_rate = (r_rate > 18'sd0) ? v_rate : -v_rate;
                end
            end
            afb_pkg::ACT_TICK: begin
                unique case (r_mode)
                    afb_pkg::MODE_IN: begin
                        v_lvl = v_sum;
                        if (v_sum >= v_full) begin
                            v_lvl  = v_full;
                            n_mode = afb_pkg::MODE_IDLE;
                        end
                    end
                    afb_pkg::MODE_OUT: begin
                        v_lvl = v_sum;
                        if (v_sum <= 19'sd0) begin
                            v_lvl  = '0;
                            n_mode = afb_pkg::MODE_IDLE;
                        end
                    end
                    afb_pkg::MODE_BLINK: begin
                        v_lvl = v_sum;
                        if (v_sum >= v_hi) begin
                            v_lvl  = v_hi;
                            n_rate = -r_rate;
                        end else if (v_sum <= v_lo) begin
                            v_lvl  = v_lo;
                            n_rate = -r_rate;
                        end
                    end
                    afb_pkg::MODE_IDLE: begin
                    end
                endcase
            end
        endcase
        if (v_lvl < 19'sd0) begin
            n_level = '0;
        end else if (v_lvl[afb_pkg::LEVEL_W+1:afb_pkg::LEVEL_W] != 2'b00) begin
            n_level = '1;
        end else begin
            n_level = v_lvl[afb_pkg::LEVEL_W-1:0];
        end
        // level * 255, then drop the 16 fraction bits
        v_prod = {n_level, 8'h00} - {8'h00, n_level};
        n_byte = v_prod[afb_pkg::LEVEL_W+7] ? 8'hFF : v_prod[afb_pkg::LEVEL_W+6:16];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level     <= '0;
            r_rate      <= '0;
            r_mode      <= afb_pkg::MODE_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (div_start) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (apply) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
            if (apply) begin
                r_level          <= n_level;
                r_rate           <= n_rate;
                r_mode           <= n_mode;
                r_out_valid      <= 1'b1;
                r_out.level_byte <= n_byte;
                r_out.mode       <= n_mode;
            end
        end
        if (div_start) begin
            r_cmd <= i_cmd;
        end
    end

endmodule

FILE: rtl/core/alpha_fade_blink_sequencer_core.sv
// ----------------------------------------------------------------------------
// alpha_fade_blink_sequencer_core
// Brightness sequencer: fades in, fades out or blinks a Q1.16 level and
// reports it as a byte for every item.
//
//   channel   direction   handshake               payload
//   input     in          i_in_valid/o_in_stall   i_in_item (action, duration)
//   result    out         o_out_valid/i_out_stall o_out_item (level_byte, mode)
//   config    in          i_cfg_we                i_cfg_index, i_cfg_data
//
// a tick passes the input, queue and result registers, one a cycle through the back end
// while it is idle and results do not stall; a fade or blink command holds the back end
// for the bit-serial rate divider (16 quotient bits, one a cycle, none when saturated)
// synchronous reset clears level, rate and mode, presets config; no clearing pass
// the two-entry queue lets input transfers continue while results stall
// ----------------------------------------------------------------------------
module alpha_fade_blink_sequencer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  afb_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output afb_pkg::t_out_item                  o_out_item,
    input  logic                                i_cfg_we,
    input  logic [afb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [afb_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    afb_pkg::t_cfg r_cfg;
    logic          front_valid;
    logic          front_stall;
    afb_pkg::t_cmd front_cmd;
    logic          queue_valid;
    logic          queue_stall;
    afb_pkg::t_cmd queue_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_time  <= afb_pkg::DUR_W'(1);
            r_cfg.blink_low  <= '0;
            r_cfg.blink_high <= afb_pkg::FULL_LEVEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                afb_pkg::CFG_TICK_TIME:  r_cfg.tick_time  <= i_cfg_data[afb_pkg::DUR_W-1:0];
                afb_pkg::CFG_BLINK_LOW:  r_cfg.blink_low  <= i_cfg_data;
                afb_pkg::CFG_BLINK_HIGH: r_cfg.blink_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    afb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .o_valid (front_valid),
        .i_stall (front_stall),
        .o_cmd   (front_cmd)
    );

    afb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_stall (front_stall),
        .i_cmd   (front_cmd),
        .o_valid (queue_valid),
        .i_stall (queue_stall),
        .o_cmd   (queue_cmd)
    );

    afb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (queue_valid),
        .o_stall (queue_stall),
        .i_cmd   (queue_cmd),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

`ifndef SYNTHESIS
    // fading in never reports a full level: reaching full ends the fade
    a_fade_in_below_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.mode == afb_pkg::MODE_IN))
            |-> (o_out_item.level_byte != 8'hFF))
        else $error("fade in reported a full level");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a full queue pushes back on the input stage whenever that stage holds an item
    a_queue_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_valid && front_stall) |-> (o_in_stall && queue_valid))
        else $error("queue full without stalling the input stage");
`endif

endmodule

FILE: tb/alpha_fade_blink_sequencer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alpha_fade_blink_sequencer_core_tb
// Self-checking bench for the fade / blink sequencer. Fade, blink and tick
// transfers are queued by phase, each phase under its own register setting,
// and in most phases sent with random gaps while the result side stalls at
// random. The level byte and mode are predicted at every input transfer and
// compared in order with every result transfer.
// ----------------------------------------------------------------------------
module alpha_fade_blink_sequencer_core_tb;
    import afb_pkg::*;

    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     WAIT_MAX     = 17;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     PHASE_ITEMS  = 70;
    localparam longint FULL         = 65536;
    localparam longint LEVEL_MAX    = 'h1FFFF;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_TICK_TIME;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predicted sequencer state and registers
    logic [LEVEL_W-1:0]        seq_level = '0;
    logic signed [RATE_W-1:0]  seq_rate  = '0;
    t_mode                     seq_mode  = MODE_IDLE;
    logic [DUR_W-1:0]          seq_tick  = 16'd1;
    logic [LEVEL_W-1:0]        seq_low   = '0;
    logic [LEVEL_W-1:0]        seq_high  = FULL_LEVEL;

    t_in_item  pending_items[$];
    t_out_item expected_levels[$];

    logic drv_idle_en   = 1'b1;
    logic rcv_idle_en   = 1'b1;
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   gap_left      = 0;
    int   stall_left    = 0;
    int   hold_left     = 0;
    int   errors        = 0;
    int   cycles        = 0;

    alpha_fade_blink_sequencer_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_wait();
        if ($urandom_range(0, 3) == 0) begin
            return 0;
        end
        return $urandom_range(0, WAIT_MAX);
    endfunction

    function automatic longint step_size(logic [DUR_W-1:0] dur);
        longint quot;
        if (dur == '0) begin
            return FULL;
        end
        quot = (longint'(seq_tick) << 16) / longint'(dur);
        if (quot > FULL) begin
            quot = FULL;
        end
        return quot;
    endfunction

    function automatic t_out_item sequence_step(t_in_item it);
        longint    lvl;
        longint    rate;
        longint    lo;
        longint    hi;
        longint    scaled;
        t_out_item res;
        lvl  = seq_level;
        rate = seq_rate;
        lo   = seq_low;
        hi   = seq_high;
        case (t_action'(it.action))
            ACT_FADE_IN: begin
                if (lvl == FULL) begin
                    seq_mode = MODE_IDLE;
                end else if (it.duration == '0) begin
                    seq_mode = MODE_IDLE;
                    lvl      = FULL;
                end else begin
                    lvl      = 0;
                    seq_mode = MODE_IN;
                    rate     = step_size(it.duration);
                end
            end
            ACT_FADE_OUT: begin
                if (it.duration == '0) begin
                    seq_mode = MODE_IDLE;
                    lvl      = 0;
                end else begin
                    lvl      = FULL;
                    seq_mode = MODE_OUT;
                    rate     = -step_size(it.duration);
                end
            end
            ACT_BLINK: begin
                if (seq_mode == MODE_IDLE || seq_mode == MODE_BLINK) begin
                    seq_mode = MODE_BLINK;
                    rate     = (rate > 0) ? step_size(it.duration) : -step_size(it.duration);
                end
            end
            default: begin
                if (seq_mode == MODE_IN) begin
                    lvl += rate;
                    if (lvl >= FULL) begin
                        lvl      = FULL;
                        seq_mode = MODE_IDLE;
                    end
                end else if (seq_mode == MODE_OUT) begin
                    lvl += rate;
                    if (lvl <= 0) begin
                        lvl      = 0;
                        seq_mode = MODE_IDLE;
                    end
                end else if (seq_mode == MODE_BLINK) begin
                    lvl += rate;
                    if (lvl >= hi) begin
                        lvl  = hi;
                        rate = -rate;
                    end else if (lvl <= lo) begin
                        lvl  = lo;
                        rate = -rate;
                    end
                end
            end
        endcase
        if (lvl < 0) begin
            lvl = 0;
        end
        if (lvl > LEVEL_MAX) begin
            lvl = LEVEL_MAX;
        end
        scaled = (lvl * 255) >>> 16;
        if (scaled > 255) begin
            scaled = 255;
        end
        seq_level      = lvl[LEVEL_W-1:0];
        seq_rate       = rate[RATE_W-1:0];
        res.level_byte = scaled[BYTE_W-1:0];
        res.mode       = seq_mode;
        return res;
    endfunction

    // input side
    always @(posedge clk) begin : drive_items
        logic busy;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            busy = in_valid;
            if (in_valid && !in_stall) begin
                expected_levels.push_back(sequence_step(in_item));
                busy     = 1'b0;
                gap_left = drv_idle_en ? draw_wait() : 0;
            end
            if (!busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() != 0) begin
                    in_item <= pending_items.pop_front();
                    busy = 1'b1;
                end
            end
            in_valid <= busy;
        end
    end

    // result side
    always @(posedge clk) begin : check_results
        t_out_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (hold_requests != hold_served) begin
                hold_left   = HOLD_CYCLES;
                hold_served = hold_requests;
            end
            if (out_valid && !out_stall) begin
                if (expected_levels.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected transfer, level_byte %0d mode %0d",
                             $time, out_item.level_byte, out_item.mode);
                end else begin
                    want = expected_levels.pop_front();
                    if (out_item.level_byte !== want.level_byte) begin
                        errors++;
                        $display("%0t: level_byte expected %0d actual %0d",
                                 $time, want.level_byte, out_item.level_byte);
                    end
                    if (out_item.mode !== want.mode) begin
                        errors++;
                        $display("%0t: mode expected %0d actual %0d",
                                 $time, want.mode, out_item.mode);
                    end
                end
                stall_left = rcv_idle_en ? draw_wait() : 0;
            end
            out_stall <= (hold_left > 0) || (stall_left > 0);
            if (hold_left > 0) begin
                hold_left--;
            end
            if (stall_left > 0) begin
                stall_left--;
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL alpha_fade_blink_sequencer_core");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_TICK_TIME:  seq_tick = data[DUR_W-1:0];
            CFG_BLINK_LOW:  seq_low  = data;
            CFG_BLINK_HIGH: seq_high = data;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [DUR_W-1:0] tick, logic [LEVEL_W-1:0] lo,
                              logic [LEVEL_W-1:0] hi);
        write_reg(CFG_TICK_TIME, {1'b0, tick});
        write_reg(CFG_BLINK_LOW, lo);
        write_reg(CFG_BLINK_HIGH, hi);
        @(negedge clk);
    endtask

    task automatic set_idling(logic drv, logic rcv);
        drv_idle_en <= drv;
        rcv_idle_en <= rcv;
    endtask

    task automatic queue_item(t_action act, logic [DUR_W-1:0] dur);
        pending_items.push_back(t_in_item'{action: act, duration: dur});
    endtask

    task automatic queue_ticks(int n);
        repeat (n) queue_item(ACT_TICK, DUR_W'($urandom_range(0, 65535)));
    endtask

    task automatic wait_quiet();
        do @(negedge clk);
        while (pending_items.size() != 0 || expected_levels.size() != 0 || in_valid);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [DUR_W-1:0] pick_duration();
        longint d;
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return DUR_W'($urandom_range(0, 65535));
            default: begin
                d = longint'(seq_tick) * $urandom_range(1, 12);
                if (d == 0) begin
                    d = $urandom_range(1, 50);
                end
                if (d > 65535) begin
                    d = 65535;
                end
                return d[DUR_W-1:0];
            end
        endcase
    endfunction

    function automatic logic [LEVEL_W-1:0] pick_bound();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return FULL_LEVEL;
            default: return LEVEL_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [DUR_W-1:0] pick_tick();
        case ($urandom_range(0, 5))
            0:       return 16'd1;
            1:       return 16'hFFFF;
            default: return DUR_W'($urandom_range(1, 3000));
        endcase
    endfunction

    // mostly a command followed by a run of ticks, some lone random items
    task automatic add_traffic(int n);
        int count;
        int run;
        count = 0;
        while (count < n) begin
            if ($urandom_range(0, 9) < 8) begin
                queue_item(t_action'($urandom_range(1, 3)), pick_duration());
                run = $urandom_range(1, 20);
                queue_ticks(run);
                count += run + 1;
            end else begin
                queue_item(t_action'($urandom_range(0, 3)), DUR_W'($urandom_range(0, 65535)));
                count++;
            end
        end
    endtask

    initial begin : stimulus
        logic [LEVEL_W-1:0] lo;
        logic [LEVEL_W-1:0] hi;
        logic [LEVEL_W-1:0] tmp;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset setting: jumps, full step, slowest fade, ignored blink, sign keeping
        queue_ticks(1);
        queue_item(ACT_FADE_IN, 16'd0);
        queue_item(ACT_FADE_IN, 16'd5);
        queue_ticks(1);
        queue_item(ACT_FADE_OUT, 16'd0);
        queue_item(ACT_FADE_OUT, 16'd1);
        queue_ticks(1);
        queue_item(ACT_FADE_IN, 16'hFFFF);
        queue_item(ACT_BLINK, 16'd0);
        queue_ticks(1);
        queue_item(ACT_FADE_OUT, 16'd3);
        queue_ticks(4);
        queue_item(ACT_BLINK, 16'd0);
        queue_ticks(2);
        queue_item(ACT_BLINK, 16'hFFFF);
        queue_ticks(1);
        queue_item(ACT_BLINK, 16'd2);
        queue_ticks(2);
        wait_quiet();

        // zero tick length: fades never end, blink rate stays zero
        set_config(16'd0, '0, FULL_LEVEL);
        set_idling(1'b0, 1'b0);
        queue_item(ACT_FADE_IN, 16'd7);
        queue_ticks(3);
        queue_item(ACT_BLINK, 16'd4);
        queue_item(ACT_FADE_OUT, 16'd9);
        queue_ticks(2);
        queue_item(ACT_FADE_OUT, 16'd0);
        queue_item(ACT_BLINK, 16'd4);
        queue_ticks(2);
        wait_quiet();

        // upper bounce above full
        set_config(16'hFFFF, 17'h08000, 17'h1FFFF);
        set_idling(1'b1, 1'b1);
        queue_item(ACT_FADE_IN, 16'd0);
        queue_item(ACT_BLINK, 16'hFFFF);
        queue_ticks(6);
        wait_quiet();

        // lower bound above upper bound
        set_config(16'd1, FULL_LEVEL, '0);
        queue_item(ACT_BLINK, 16'd1);
        queue_ticks(5);
        queue_item(ACT_BLINK, 16'd0);
        queue_ticks(2);
        wait_quiet();

        for (int ph = 0; ph < 8; ph++) begin
            lo = pick_bound();
            hi = pick_bound();
            if (lo > hi && $urandom_range(0, 4) != 0) begin
                tmp = lo;
                lo  = hi;
                hi  = tmp;
            end
            set_config(pick_tick(), lo, hi);
            case (ph)
                0: set_idling(1'b0, 1'b0);
                2: begin
                    // long result hold while items keep coming
                    set_idling(1'b0, 1'b1);
                    hold_requests <= hold_requests + 1;
                end
                default: set_idling($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
            endcase
            @(negedge clk);
            add_traffic(PHASE_ITEMS);
            wait_quiet();
        end

        if (expected_levels.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_levels.size());
        end
        if (errors == 0) begin
            $display("PASS alpha_fade_blink_sequencer_core");
        end else begin
            $display("FAIL alpha_fade_blink_sequencer_core");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/afb_pkg.sv
rtl/core/afb_front.sv
rtl/core/afb_queue.sv
rtl/core/afb_div.sv
rtl/core/afb_back.sv
rtl/core/alpha_fade_blink_sequencer_core.sv
tb/alpha_fade_blink_sequencer_core_tb.sv
